// ===== hw/rtl/b64lw_pkg.sv =====
// package for the base64 line wrapping encoder
// holds the character constants, the run type and the alphabet lookup; no dependencies
package b64lw_pkg;

    // default register width of the line length
    localparam int LINE_LENGTH_BITS_DEF = 10;

    // line length after reset, cut to the register width where it is used
    localparam logic [15:0] LINE_LENGTH_RESET = 16'd76;

    // characters of a run: four group characters plus cr lf
    localparam int RUN_CHARS = 6;
    localparam int RUN_LEN_BITS = 3;

    localparam logic [7:0] PAD_CHAR = 8'h3d;
    localparam logic [7:0] CR_CHAR  = 8'h0d;
    localparam logic [7:0] LF_CHAR  = 8'h0a;

    localparam logic [RUN_LEN_BITS-1:0] GROUP_LEN = 3'd4;
    localparam logic [RUN_LEN_BITS-1:0] BREAK_LEN = 3'd6;

    // characters produced by one input word, sent first to last
    typedef struct packed {
        logic [RUN_CHARS-1:0][7:0]   chars;
        logic [RUN_LEN_BITS-1:0]     len;
    } run_t;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] b64_char(input logic [5:0] sextet);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, sextet};
        if (sextet < 6'd26) begin
            c = 8'h41 + v;
        end else if (sextet < 6'd52) begin
            c = 8'h61 + (v - 8'd26);
        end else if (sextet < 6'd62) begin
            c = 8'h30 + (v - 8'd52);
        end else if (sextet == 6'd62) begin
            c = 8'h2b;
        end else begin
            c = 8'h2f;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/b64lw_byte_if.sv =====
// channel for raw message bytes
// valid/ready handshake carrying one byte and its end of message flag; no dependencies
interface b64lw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== hw/rtl/b64lw_char_if.sv =====
// channel for encoded characters
// valid/ready handshake carrying one character and its end of run flag; no dependencies
interface b64lw_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== hw/rtl/b64lw_encoder.sv =====
// input register, group gathering and column tracking of the encoder
// depends on b64lw_pkg and b64lw_byte_if; hands finished runs to the serializer
module b64lw_encoder #(
    parameter int LINE_LENGTH_BITS = b64lw_pkg::LINE_LENGTH_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [LINE_LENGTH_BITS-1:0] cfg_data,
    b64lw_byte_if.sink                  raw,
    output logic                        run_valid,
    output b64lw_pkg::run_t             run,
    input  logic                        slot_free
);
    import b64lw_pkg::*;

    localparam int COL_BITS = LINE_LENGTH_BITS + 1;

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_eom_reg;
    logic [LINE_LENGTH_BITS-1:0] line_length_reg;
    logic [1:0]                  bytes_held_reg, bytes_held_next;
    logic [15:0]                 held_bits_reg, held_bits_next;
    logic [COL_BITS-1:0]         column_reg, column_next;

    logic                        emit;
    logic                        advance;
    logic [23:0]                 group;
    logic [1:0]                  npad;
    logic [COL_BITS-1:0]         col_plus4;
    logic                        line_break;

    // line length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_length_reg <= LINE_LENGTH_RESET[LINE_LENGTH_BITS-1:0];
        end else if (cfg_we) begin
            line_length_reg <= cfg_data;
        end
    end

    // input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (raw.ready) begin
            in_valid_reg <= raw.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready) begin
            in_byte_reg <= raw.data_byte;
            in_eom_reg  <= raw.end_of_message;
        end
    end

    // group forming: complete group, or flush of one or two bytes at the end of the message
    always_comb
    begin
        emit  = 1'b0;
        group = 24'd0;
        npad  = 2'd0;
        if (bytes_held_reg == 2'd2) begin
            emit  = 1'b1;
            group = {held_bits_reg, in_byte_reg};
        end else if (in_eom_reg) begin
            emit = 1'b1;
            if (bytes_held_reg == 2'd0) begin
                group = {in_byte_reg, 16'd0};
                npad  = 2'd2;
            end else begin
                group = {held_bits_reg[7:0], in_byte_reg, 8'd0};
                npad  = 2'd1;
            end
        end
    end

    // column advance and line break decision
    assign col_plus4  = column_reg + COL_BITS'(4);
    assign line_break = (line_length_reg != '0) && (col_plus4 >= {1'b0, line_length_reg});

    // run contents
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            if (3'(i) + {1'b0, npad} >= 3'd4) begin
                run.chars[i] = PAD_CHAR;
            end else begin
                run.chars[i] = b64_char(group[(3 - i) * 6 +: 6]);
            end
        end
        run.chars[4] = CR_CHAR;
        run.chars[5] = LF_CHAR;
        run.len      = line_break ? BREAK_LEN : GROUP_LEN;
    end

    // handshake: a word without output never waits for the serializer
    assign advance   = in_valid_reg && (!emit || slot_free);
    assign raw.ready = !in_valid_reg || advance;
    assign run_valid = in_valid_reg && emit && slot_free;

    // next state of the gathering and the column
    always_comb
    begin
        bytes_held_next = bytes_held_reg;
        held_bits_next  = held_bits_reg;
        column_next     = column_reg;
        if (emit) begin
            bytes_held_next = 2'd0;
            held_bits_next  = 16'd0;
            column_next     = line_break ? '0 : col_plus4;
        end else begin
            bytes_held_next = bytes_held_reg + 2'd1;
            held_bits_next  = {held_bits_reg[7:0], in_byte_reg};
        end
        if (in_eom_reg) begin
            column_next = '0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bytes_held_reg <= 2'd0;
            held_bits_reg  <= 16'd0;
            column_reg     <= '0;
        end else if (advance) begin
            bytes_held_reg <= bytes_held_next;
            held_bits_reg  <= held_bits_next;
            column_reg     <= column_next;
        end
    end

`ifndef NO_ASSERTIONS
    // never more than two bytes held toward a group
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_held_reg != 2'd3)
        else $error("bytes held out of range");

    // a held word without output leaves at once
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !emit |-> raw.ready)
        else $error("word without output stalled");

    // after a line break the column restarts
    a_break_clears: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run.len == BREAK_LEN |=> column_reg == '0)
        else $error("column not cleared after line break");
`endif
endmodule

// ===== hw/rtl/b64lw_serializer.sv =====
// output stage: holds one run and sends its characters one word per cycle while encoded is ready
// depends on b64lw_pkg and b64lw_char_if
module b64lw_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            run_valid,
    input  b64lw_pkg::run_t run,
    output logic            slot_free,
    b64lw_char_if.source    encoded
);
    import b64lw_pkg::*;

    run_t                    run_reg;
    logic                    valid_reg;
    logic [RUN_LEN_BITS-1:0] idx_reg;
    logic                    last;
    logic                    take;

    assign last      = idx_reg == RUN_LEN_BITS'(run_reg.len - 3'd1);
    assign take      = valid_reg && encoded.ready;
    assign slot_free = !valid_reg || (encoded.ready && last);

    assign encoded.valid       = valid_reg;
    assign encoded.out_char    = run_reg.chars[idx_reg];
    assign encoded.last_of_run = last;

    // run payload
    always_ff @(posedge clk)
    begin
        if (run_valid) begin
            run_reg <= run;
        end
    end

    // run control: valid flag and character index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (run_valid) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (take) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // a held run is four characters or six with cr lf
    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (run_reg.len == GROUP_LEN || run_reg.len == BREAK_LEN))
        else $error("illegal run length");

    // index stays inside the run
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> idx_reg < run_reg.len)
        else $error("character index past run end");

    // a new run only arrives into a free slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> slot_free)
        else $error("run loaded over a pending run");

    // taking the last character with nothing new empties the stage
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        take && last && !run_valid |=> !valid_reg)
        else $error("stage not emptied after last character");
`endif
endmodule

// ===== hw/rtl/base64_line_wrapping_encoder.sv =====
// top level of the base64 line wrapping encoder
// depends on b64lw_pkg, b64lw_byte_if, b64lw_char_if, b64lw_encoder and b64lw_serializer

// Takes one raw byte per word on raw and sends base64 characters, '=' padding and
// CR LF line breaks one per word on encoded; last_of_run marks the final character
// caused by an input byte. A byte that completes a group, or ends the message, makes
// a run of four characters, six when the line length is reached. A byte passes an
// input register and then the output register, where its first character is valid
// on encoded; it waits in the input register while the previous run is still sent.
// The output stage sends one character per cycle while encoded is ready: bytes that
// only gather are taken every cycle, and a byte that makes a run is taken once the
// previous run's last character is taken or the output stage is empty. line_length
// is to be written through cfg_we/cfg_data only while the block is idle; the block
// does not enforce this itself. Zero disables breaks.
module base64_line_wrapping_encoder #(
    parameter int LINE_LENGTH_BITS = b64lw_pkg::LINE_LENGTH_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [LINE_LENGTH_BITS-1:0] cfg_data,
    b64lw_byte_if.sink                  raw,
    b64lw_char_if.source                encoded
);
    import b64lw_pkg::*;

    logic run_valid;
    run_t run;
    logic slot_free;

    // gathering, padding and column tracking
    b64lw_encoder #(
        .LINE_LENGTH_BITS(LINE_LENGTH_BITS)
    ) u_encoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .raw       (raw),
        .run_valid (run_valid),
        .run       (run),
        .slot_free (slot_free)
    );

    // one character per word to the output
    b64lw_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_valid (run_valid),
        .run       (run),
        .slot_free (slot_free),
        .encoded   (encoded)
    );
endmodule
